@@ design/cflts_pkg.sv @@
package cflts_pkg;

    localparam int HALF_W = 32;
    localparam int WORD_W = 64;
    localparam int PROD_W = 128;
    localparam int SUM_W  = 40;

    function automatic logic [HALF_W-1:0] sat32(input logic [WORD_W-1:0] v);
        logic [HALF_W-1:0] r;
        r = (v[WORD_W-1:HALF_W] != '0) ? {HALF_W{1'b1}} : v[HALF_W-1:0];
        return r;
    endfunction

endpackage

@@ design/cflts_mul.sv @@
module cflts_mul
    import cflts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    output logic [PROD_W-1:0] prod,
    output logic              done
);

    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] b_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [PROD_W-1:0] acc_next;
    logic [1:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [HALF_W-1:0] pa;
    logic [HALF_W-1:0] pb;
    logic [WORD_W-1:0] pp;
    logic [PROD_W-1:0] pp_shift;

    always_comb
    begin
        pa = cnt_reg[0] ? a_reg[WORD_W-1:HALF_W] : a_reg[HALF_W-1:0];
        pb = cnt_reg[1] ? b_reg[WORD_W-1:HALF_W] : b_reg[HALF_W-1:0];
        pp = {{HALF_W{1'b0}}, pa} * {{HALF_W{1'b0}}, pb};
        case (cnt_reg)
            2'd0:    pp_shift = {{WORD_W{1'b0}}, pp};
            2'd3:    pp_shift = {pp, {WORD_W{1'b0}}};
            default: pp_shift = {{HALF_W{1'b0}}, pp, {HALF_W{1'b0}}};
        endcase
        acc_next = acc_reg + pp_shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

@@ design/cflts_div.sv @@
module cflts_div
    import cflts_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [HALF_W:0]   num,
    input  logic [WORD_W-1:0] den,
    output logic [WORD_W-1:0] quo,
    output logic              done
);

    localparam int NUM_W = HALF_W + 1 + FRACTION_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  sh_reg;
    logic [NUM_W-1:0]  q_reg;
    logic [NUM_W-1:0]  q_next;
    logic [WORD_W:0]   rem_reg;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   rem_next;
    logic [WORD_W-1:0] den_reg;
    logic [WORD_W-1:0] out_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              ge;

    always_comb
    begin
        trial    = {rem_reg[WORD_W-1:0], sh_reg[NUM_W-1]};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? (trial - {1'b0, den_reg}) : trial;
        q_next   = {q_reg[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (num == '0 || den == '0)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CNT_W'(NUM_W);
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= {num, {FRACTION_BITS{1'b0}}};
            rem_reg <= '0;
            q_reg   <= '0;
            den_reg <= den;
            if (num == '0)
            begin
                out_reg <= '0;
            end
            else if (den == '0)
            begin
                out_reg <= {WORD_W{1'b1}};
            end
        end
        else if (busy_reg)
        begin
            sh_reg  <= {sh_reg[NUM_W-2:0], 1'b0};
            rem_reg <= rem_next;
            q_reg   <= q_next;
            if (cnt_reg == CNT_W'(1))
            begin
                out_reg <= {{(WORD_W-NUM_W){1'b0}}, q_next};
            end
        end
    end

    assign quo  = out_reg;
    assign done = done_reg;

endmodule

@@ design/cflts_sqrt.sv @@
module cflts_sqrt
    import cflts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] x,
    output logic [HALF_W-1:0] root,
    output logic              done
);

    logic [WORD_W-1:0] x_reg;
    logic [WORD_W-1:0] r_reg;
    logic [WORD_W-1:0] bit_reg;
    logic [WORD_W-1:0] t;
    logic [4:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              take;

    always_comb
    begin
        t    = r_reg + bit_reg;
        take = x_reg >= t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= x;
            r_reg   <= '0;
            bit_reg <= {2'b01, {(WORD_W-2){1'b0}}};
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                x_reg <= x_reg - t;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign root = r_reg[HALF_W-1:0];
    assign done = done_reg;

endmodule

@@ design/cfl_local_time_step.sv @@
// channel  | direction | valid/ready        | data
// s_*      | in        | s_tvalid/s_tready  | s_tdata 320b, s_tlast, s_tuser 1b
// m_*      | out       | m_tvalid/m_tready  | m_tdata 160b, m_tuser 1b
// cfg_*    | in        | cfg_we             | cfg_index 2b, cfg_data 32b
//
// A beat runs its multiplies of four partial products, a square root and its
// divides in turn; viscous mode adds the viscous steps and a last-direction
// beat adds the time-step divides. A divide with a zero operand ends early, and
// an output stall holds the beat.
// Reset clears the sum, loads the minimum with 1000.0 and the registers with
// their defaults. A stalled result waits in the output register while the
// next beat is taken; that beat then holds until the register frees.
module cfl_local_time_step
    import cflts_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vel_u, vel_v, vel_w, sound_speed, metric_x, metric_y, metric_z,
    // density, cell_volume, viscosity, zero pad
    input  logic [319:0] s_tdata,
    input  logic         s_tlast,
    // new_sweep
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // inviscid_radius, viscous_radius, dt_physical, dt_over_volume,
    // min_time_step
    output logic [159:0] m_tdata,
    // dt_valid
    output logic         m_tuser,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam logic [1:0] CFG_CFL  = 2'd0;
    localparam logic [1:0] CFG_RE   = 2'd1;
    localparam logic [1:0] CFG_CSRV = 2'd2;
    localparam logic [1:0] CFG_VEN  = 2'd3;

    localparam logic [WORD_W-1:0] START_WIDE = 64'd1000 << FRACTION_BITS;
    localparam logic [HALF_W-1:0] START_MIN  = sat32(START_WIDE);
    localparam logic [SUM_W:0]    SUM_MAX    = {1'b0, {SUM_W{1'b1}}};

    typedef enum logic [12:0] {
        ST_IDLE = 13'h0001,
        ST_DOT  = 13'h0002,
        ST_SQRT = 13'h0004,
        ST_CG   = 13'h0008,
        ST_RR   = 13'h0010,
        ST_RV   = 13'h0020,
        ST_DR   = 13'h0040,
        ST_RG   = 13'h0080,
        ST_RS   = 13'h0100,
        ST_SUM  = 13'h0200,
        ST_DT   = 13'h0400,
        ST_DV   = 13'h0800,
        ST_OUT  = 13'h1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [31:0] cfl_reg;
    logic [31:0] re_reg;
    logic [31:0] csrv_reg;
    logic        ven_reg;

    logic [31:0] vm_reg [3];
    logic [31:0] mm_reg [3];
    logic [2:0]  sd_reg;
    logic [30:0] c_reg;
    logic [30:0] rho_reg;
    logic [30:0] vol_reg;
    logic [30:0] mu_reg;
    logic        last_reg;
    logic        sweep_reg;

    logic [1:0]        lane_reg;
    logic              sq_pass_reg;
    logic              issue_reg;
    logic [WORD_W-1:0] pos_reg;
    logic [WORD_W-1:0] negs_reg;
    logic [WORD_W-1:0] sq_reg;
    logic [WORD_W-1:0] dot_reg;
    logic [HALF_W-1:0] glen_reg;
    logic [WORD_W-1:0] t_reg;
    logic [WORD_W-1:0] d_reg;
    logic [WORD_W-1:0] r_reg;
    logic [HALF_W-1:0] inv_reg;
    logic [HALF_W-1:0] visc_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [HALF_W-1:0] min_reg;
    logic [HALF_W-1:0] dt_reg;
    logic [HALF_W-1:0] dtv_reg;

    logic         m_tvalid_reg;
    logic [159:0] m_tdata_reg;
    logic         m_tuser_reg;

    logic [31:0] vel_u;
    logic [31:0] vel_v;
    logic [31:0] vel_w;
    logic [31:0] metric_x;
    logic [31:0] metric_y;
    logic [31:0] metric_z;

    logic              mul_start;
    logic [WORD_W-1:0] mul_a;
    logic [WORD_W-1:0] mul_b;
    logic [PROD_W-1:0] mul_prod;
    logic              mul_done;
    logic [WORD_W-1:0] qm;

    logic              div_start;
    logic [HALF_W:0]   div_num;
    logic [WORD_W-1:0] div_den;
    logic [WORD_W-1:0] div_quo;
    logic              div_done;

    logic              sqrt_start;
    logic [HALF_W-1:0] sqrt_root;
    logic              sqrt_done;

    logic              accept;
    logic              out_load;
    logic [WORD_W-1:0] inv_wide;
    logic [SUM_W:0]    sum_wide;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        logic [31:0] r;
        r = v[31] ? (~v + 32'd1) : v;
        return r;
    endfunction

    assign vel_u    = s_tdata[31:0];
    assign vel_v    = s_tdata[63:32];
    assign vel_w    = s_tdata[95:64];
    assign metric_x = s_tdata[158:127];
    assign metric_y = s_tdata[190:159];
    assign metric_z = s_tdata[222:191];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_DOT:
            begin
                mul_a = {32'd0, sq_pass_reg ? mm_reg[lane_reg] : vm_reg[lane_reg]};
                mul_b = {32'd0, mm_reg[lane_reg]};
            end
            ST_CG:
            begin
                mul_a = {33'd0, c_reg};
                mul_b = {32'd0, glen_reg};
            end
            ST_RR:
            begin
                mul_a = {32'd0, re_reg};
                mul_b = {33'd0, rho_reg};
            end
            ST_RV:
            begin
                mul_a = t_reg;
                mul_b = {33'd0, vol_reg};
            end
            ST_RG:
            begin
                mul_a = r_reg;
                mul_b = sq_reg >> FRACTION_BITS;
            end
            ST_RS:
            begin
                mul_a = t_reg;
                mul_b = {32'd0, csrv_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        div_num = '0;
        div_den = '0;
        case (state_reg)
            ST_DR:
            begin
                div_num = {1'b0, mu_reg, 1'b0};
                div_den = d_reg;
            end
            ST_DT:
            begin
                div_num = {1'b0, cfl_reg};
                div_den = {{(WORD_W-SUM_W){1'b0}}, sum_reg};
            end
            ST_DV:
            begin
                div_num = {1'b0, dt_reg};
                div_den = {33'd0, vol_reg};
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    assign mul_start  = !issue_reg && ((state_reg == ST_DOT) || (state_reg == ST_CG)
                        || (state_reg == ST_RR) || (state_reg == ST_RV)
                        || (state_reg == ST_RG) || (state_reg == ST_RS));
    assign div_start  = !issue_reg && ((state_reg == ST_DR) || (state_reg == ST_DT)
                        || (state_reg == ST_DV));
    assign sqrt_start = !issue_reg && (state_reg == ST_SQRT);

    assign qm = (mul_prod[PROD_W-1:WORD_W] != '0) ? {WORD_W{1'b1}}
              : (mul_prod[WORD_W-1:0] >> FRACTION_BITS);
    assign inv_wide = (dot_reg >> FRACTION_BITS) + (mul_prod[WORD_W-1:0] >> FRACTION_BITS);
    assign sum_wide = {1'b0, sum_reg} + {9'd0, inv_reg} + {9'd0, visc_reg};

    cflts_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (mul_prod),
        .done  (mul_done)
    );

    cflts_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .done  (div_done)
    );

    cflts_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .x     (sq_reg),
        .root  (sqrt_root),
        .done  (sqrt_done)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_DOT;
            ST_DOT:  if (mul_done && sq_pass_reg && lane_reg == 2'd2) state_next = ST_SQRT;
            ST_SQRT: if (sqrt_done) state_next = ST_CG;
            ST_CG:   if (mul_done) state_next = ven_reg ? ST_RR : ST_SUM;
            ST_RR:   if (mul_done) state_next = ST_RV;
            ST_RV:   if (mul_done) state_next = ST_DR;
            ST_DR:   if (div_done) state_next = ST_RG;
            ST_RG:   if (mul_done) state_next = ST_RS;
            ST_RS:   if (mul_done) state_next = ST_SUM;
            ST_SUM:  state_next = last_reg ? ST_DT : ST_OUT;
            ST_DT:   if (div_done) state_next = ST_DV;
            ST_DV:   if (div_done) state_next = ST_OUT;
            ST_OUT:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            issue_reg    <= 1'b0;
            lane_reg     <= '0;
            sq_pass_reg  <= 1'b0;
            cfl_reg      <= 32'h0001_0000;
            re_reg       <= 32'h0001_0000;
            csrv_reg     <= 32'h0001_0000;
            ven_reg      <= 1'b0;
            sum_reg      <= '0;
            min_reg      <= START_MIN;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CFL:  cfl_reg  <= cfg_data;
                    CFG_RE:   re_reg   <= cfg_data;
                    CFG_CSRV: csrv_reg <= cfg_data;
                    CFG_VEN:  ven_reg  <= cfg_data[0];
                    default:  ven_reg  <= ven_reg;
                endcase
            end
            if (mul_start || div_start || sqrt_start)
            begin
                issue_reg <= 1'b1;
            end
            else if (mul_done || div_done || sqrt_done)
            begin
                issue_reg <= 1'b0;
            end
            if (accept)
            begin
                lane_reg    <= '0;
                sq_pass_reg <= 1'b0;
            end
            else if (state_reg == ST_DOT && mul_done)
            begin
                if (lane_reg == 2'd2)
                begin
                    lane_reg    <= '0;
                    sq_pass_reg <= 1'b1;
                end
                else
                begin
                    lane_reg <= lane_reg + 2'd1;
                end
            end
            if (state_reg == ST_SUM)
            begin
                sum_reg <= sum_wide[SUM_W] ? SUM_MAX[SUM_W-1:0] : sum_wide[SUM_W-1:0];
                if (sweep_reg)
                begin
                    min_reg <= START_MIN;
                end
            end
            if (state_reg == ST_DV && div_done)
            begin
                sum_reg <= '0;
                if (dt_reg < min_reg)
                begin
                    min_reg <= dt_reg;
                end
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vm_reg[0] <= mag32(vel_u);
            vm_reg[1] <= mag32(vel_v);
            vm_reg[2] <= mag32(vel_w);
            mm_reg[0] <= mag32(metric_x);
            mm_reg[1] <= mag32(metric_y);
            mm_reg[2] <= mag32(metric_z);
            sd_reg    <= {vel_w[31] ^ metric_z[31], vel_v[31] ^ metric_y[31],
                          vel_u[31] ^ metric_x[31]};
            c_reg     <= s_tdata[126:96];
            rho_reg   <= s_tdata[253:223];
            vol_reg   <= s_tdata[284:254];
            mu_reg    <= s_tdata[315:285];
            last_reg  <= s_tlast;
            sweep_reg <= s_tuser;
            pos_reg   <= '0;
            negs_reg  <= '0;
            sq_reg    <= '0;
        end
        if (state_reg == ST_DOT && mul_done)
        begin
            if (sq_pass_reg)
            begin
                sq_reg <= sq_reg + mul_prod[WORD_W-1:0];
            end
            else if (sd_reg[lane_reg])
            begin
                negs_reg <= negs_reg + mul_prod[WORD_W-1:0];
            end
            else
            begin
                pos_reg <= pos_reg + mul_prod[WORD_W-1:0];
            end
        end
        if (state_reg == ST_SQRT && sqrt_done)
        begin
            glen_reg <= sqrt_root;
            dot_reg  <= (pos_reg >= negs_reg) ? (pos_reg - negs_reg) : (negs_reg - pos_reg);
        end
        if (state_reg == ST_CG && mul_done)
        begin
            inv_reg  <= sat32(inv_wide);
            visc_reg <= '0;
        end
        if ((state_reg == ST_RR || state_reg == ST_RG) && mul_done)
        begin
            t_reg <= qm;
        end
        if (state_reg == ST_RV && mul_done)
        begin
            d_reg <= qm;
        end
        if (state_reg == ST_DR && div_done)
        begin
            r_reg <= div_quo;
        end
        if (state_reg == ST_RS && mul_done)
        begin
            visc_reg <= sat32(qm);
        end
        if (state_reg == ST_DT && div_done)
        begin
            dt_reg <= sat32(div_quo);
        end
        if (state_reg == ST_DV && div_done)
        begin
            dtv_reg <= sat32(div_quo);
        end
        if (out_load)
        begin
            m_tuser_reg <= last_reg;
            m_tdata_reg <= {last_reg ? min_reg : 32'd0,
                            last_reg ? dtv_reg : 32'd0,
                            last_reg ? dt_reg  : 32'd0,
                            visc_reg, inv_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ design/cflts_checker.sv @@
module cflts_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [159:0] m_tdata,
    input logic         m_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("beat taken while busy");

    a_nodt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[159:64] == 96'd0)
        else $error("time step fields set without dt_valid");

    a_min: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[159:128] <= m_tdata[95:64])
        else $error("minimum above time step");

endmodule

bind cfl_local_time_step cflts_checker u_cflts_checker (.*);
